// ===== rtl/hvd_pkg.sv =====
// ----------------------------------------------------------------------------
// hvd_pkg
// Shared constants and CORDIC angle table for the haversine distance pipeline.
// ----------------------------------------------------------------------------
package hvd_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int CORDIC_STAGES_DEF   = 24;

    localparam logic [22:0] RADIUS_RESET = 23'd6371000;
    localparam logic [31:0] GAIN_Q30     = 32'h26DD3B6A;
    localparam logic [31:0] PI_Q30       = 32'hC90FDAA2;
    localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
    localparam logic [24:0] DIST_MAX     = 25'h1FF_FFFF;

    // arctan(2^-i) as a binary angle, 2^32 per turn
    function automatic logic [31:0] atan_bam(input logic [5:0] i);
        logic [31:0] r;
        begin
            case (i)
                6'd0:  r = 32'h20000000;
                6'd1:  r = 32'h12E4051D;
                6'd2:  r = 32'h09FB385B;
                6'd3:  r = 32'h051111D4;
                6'd4:  r = 32'h028B0D43;
                6'd5:  r = 32'h0145D7E1;
                6'd6:  r = 32'h00A2F61E;
                6'd7:  r = 32'h00517C55;
                6'd8:  r = 32'h0028BE53;
                6'd9:  r = 32'h00145F2E;
                6'd10: r = 32'h000A2F98;
                6'd11: r = 32'h000517CC;
                6'd12: r = 32'h00028BE6;
                6'd13: r = 32'h000145F3;
                6'd14: r = 32'h0000A2F9;
                6'd15: r = 32'h0000517C;
                6'd16: r = 32'h000028BE;
                6'd17: r = 32'h0000145F;
                6'd18: r = 32'h00000A2F;
                6'd19: r = 32'h00000517;
                6'd20: r = 32'h0000028B;
                6'd21: r = 32'h00000145;
                6'd22: r = 32'h000000A2;
                6'd23: r = 32'h00000051;
                6'd24: r = 32'h00000028;
                6'd25: r = 32'h00000014;
                6'd26: r = 32'h0000000A;
                6'd27: r = 32'h00000005;
                6'd28: r = 32'h00000002;
                6'd29: r = 32'h00000001;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/hvd_pipe.sv =====
// ----------------------------------------------------------------------------
// hvd_pipe
// Full datapath: range check, binary-angle conversion, four sin/cos CORDICs,
// haversine term, two digit-serial square roots, atan2 CORDIC, scaling.
// One stage register per CORDIC/root step; all stages advance on i_adv.
// ----------------------------------------------------------------------------
module hvd_pipe
    import hvd_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic        i_vld,
    input  logic [23:0] i_lat_a,
    input  logic [24:0] i_lon_a,
    input  logic [23:0] i_lat_b,
    input  logic [24:0] i_lon_b,
    input  logic [22:0] i_radius,
    output logic        o_vld,
    output logic [24:0] o_distance_m,
    output logic        o_range_error
);

    localparam int NS   = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int SQN  = 31;            // result bits of isqrt of a 61-bit value
    localparam int FULL = 360 << ANGLE_FRAC_BITS;
    localparam int LATL = 90 << ANGLE_FRAC_BITS;
    localparam int LONL = 180 << ANGLE_FRAC_BITS;
    localparam int CW   = 36;            // CORDIC datapath width

    // ---------------- stage 0: range check and differences ----------------
    logic             r0_v, r0_err;
    logic signed [25:0] r0_dl, r0_do, r0_la, r0_lb;
    logic signed [31:0] n_la, n_oa, n_lb, n_ob;
    logic               n_err;
    always_comb begin
        n_la = 32'(signed'(i_lat_a));
        n_lb = 32'(signed'(i_lat_b));
        n_oa = 32'(signed'(i_lon_a));
        n_ob = 32'(signed'(i_lon_b));
        n_err = (n_la < -LATL) || (n_la > LATL) ||
                (n_lb < -LATL) || (n_lb > LATL) ||
                (n_oa < -LONL) || (n_oa > LONL) ||
                (n_ob < -LONL) || (n_ob > LONL);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_adv) begin
            r0_v <= i_vld;
        end
        if (i_adv) begin
            r0_err <= n_err;
            r0_dl  <= 26'(n_la) - 26'(n_lb);
            r0_do  <= 26'(n_oa) - 26'(n_ob);
            r0_la  <= 26'(n_la);
            r0_lb  <= 26'(n_lb);
        end
    end

    // ---------------- stage 1: magnitude << shift + half divisor ----------
    // angle k: 0 dlat(sh31), 1 dlon(sh31), 2 lat_a(sh32), 3 lat_b(sh32)
    logic [3:0]  r1_neg;
    logic [59:0] r1_num [4];
    logic        r1_v, r1_err;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_adv) begin
            r1_v <= r0_v;
        end
        if (i_adv) begin
            r1_err    <= r0_err;
            r1_neg[0] <= r0_dl[25];
            r1_neg[1] <= r0_do[25];
            r1_neg[2] <= r0_la[25];
            r1_neg[3] <= r0_lb[25];
            r1_num[0] <= (60'(r0_dl[25] ? -r0_dl : r0_dl) << 31) + 60'(FULL / 2);
            r1_num[1] <= (60'(r0_do[25] ? -r0_do : r0_do) << 31) + 60'(FULL / 2);
            r1_num[2] <= (60'(r0_la[25] ? -r0_la : r0_la) << 32) + 60'(FULL / 2);
            r1_num[3] <= (60'(r0_lb[25] ? -r0_lb : r0_lb) << 32) + 60'(FULL / 2);
        end
    end

    // ---------------- stages 2..3: divide by FULL = 45 * 2^(F+3) ----------
    // Power of two is a shift, the 45 a reciprocal multiply. Legal angles
    // leave under 37 bits after the shift, so ceil(2^43 / 45) gives the exact
    // floor quotient. The 37 x 38 product is split into partial products.
    localparam int          DSH    = ANGLE_FRAC_BITS + 3;
    localparam logic [5:0]  RCP_HI = 6'h2D;
    localparam logic [31:0] RCP_LO = 32'h82D8_2D83;
    logic [36:0] w_mq [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_mq[k] = 37'(r1_num[k] >> DSH);
        end
    end
    logic [63:0] r2_ll [4];
    logic [37:0] r2_lh [4];
    logic [36:0] r2_hl [4];
    logic [10:0] r2_hh [4];
    logic [3:0]  r2_neg;
    logic        r2_v, r2_err;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_adv) begin
            r2_v <= r1_v;
        end
        if (i_adv) begin
            r2_err <= r1_err;
            r2_neg <= r1_neg;
            for (int k = 0; k < 4; k++) begin
                r2_ll[k] <= 64'(w_mq[k][31:0]) * 64'(RCP_LO);
                r2_lh[k] <= 38'(w_mq[k][31:0]) * 38'(RCP_HI);
                r2_hl[k] <= 37'(w_mq[k][36:32]) * 37'(RCP_LO);
                r2_hh[k] <= 11'(w_mq[k][36:32]) * 11'(RCP_HI);
            end
        end
    end
    logic [74:0] w_sum [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_sum[k] = 75'(r2_ll[k]) + (75'(r2_lh[k]) << 32) +
                       (75'(r2_hl[k]) << 32) + (75'(r2_hh[k]) << 64);
        end
    end
    logic [31:0] r3_q [4];
    logic [3:0]  r3_neg;
    logic        r3_v, r3_err;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_adv) begin
            r3_v <= r2_v;
        end
        if (i_adv) begin
            r3_err <= r2_err;
            r3_neg <= r2_neg;
            for (int k = 0; k < 4; k++) begin
                r3_q[k] <= w_sum[k][74:43];
            end
        end
    end

    // ---------------- quadrant fold into CORDIC rotation inputs ------------
    logic [31:0]            bam  [4];
    logic signed [CW-1:0]   c_x  [NS+1][4];
    logic signed [CW-1:0]   c_y  [NS+1][4];
    logic signed [32:0]     c_z  [NS+1][4];
    logic [3:0]             c_fl [NS+1];
    logic                   c_v  [NS+1];
    logic                   c_err[NS+1];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            logic [31:0] a;
            a = r3_neg[k] ? (32'd0 - r3_q[k]) : r3_q[k];
            bam[k] = a;
        end
    end
    logic [3:0]           rq_fl;
    logic signed [32:0]   rq_z [4];
    logic                 rq_v, rq_err;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rq_v <= 1'b0;
        end else if (i_adv) begin
            rq_v <= r3_v;
        end
        if (i_adv) begin
            rq_err <= r3_err;
            for (int k = 0; k < 4; k++) begin
                logic [31:0] a;
                logic        f;
                f = (bam[k][31:30] == 2'd1) || (bam[k][31:30] == 2'd2);
                a = f ? bam[k] + 32'h8000_0000 : bam[k];
                rq_fl[k] <= f;
                rq_z[k]  <= 33'(signed'(a));
            end
        end
    end
    always_comb begin
        c_v[0]   = rq_v;
        c_err[0] = rq_err;
        c_fl[0]  = rq_fl;
        for (int k = 0; k < 4; k++) begin
            c_x[0][k] = CW'(GAIN_Q30);
            c_y[0][k] = '0;
            c_z[0][k] = rq_z[k];
        end
    end
    for (genvar s = 0; s < NS; s++) begin : g_rot
        logic signed [CW-1:0] r_x [4];
        logic signed [CW-1:0] r_y [4];
        logic signed [32:0]   r_z [4];
        logic [3:0]           r_fl;
        logic                 r_v, r_err;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_adv) begin
                r_v <= c_v[s];
            end
            if (i_adv) begin
                r_fl  <= c_fl[s];
                r_err <= c_err[s];
                for (int k = 0; k < 4; k++) begin
                    if (!c_z[s][k][32]) begin
                        r_x[k] <= c_x[s][k] - (c_y[s][k] >>> s);
                        r_y[k] <= c_y[s][k] + (c_x[s][k] >>> s);
                        r_z[k] <= c_z[s][k] - 33'(atan_bam(6'(s)));
                    end else begin
                        r_x[k] <= c_x[s][k] + (c_y[s][k] >>> s);
                        r_y[k] <= c_y[s][k] - (c_x[s][k] >>> s);
                        r_z[k] <= c_z[s][k] + 33'(atan_bam(6'(s)));
                    end
                end
            end
        end
        assign c_x[s+1]   = r_x;
        assign c_y[s+1]   = r_y;
        assign c_z[s+1]   = r_z;
        assign c_fl[s+1]  = r_fl;
        assign c_v[s+1]   = r_v;
        assign c_err[s+1] = r_err;
    end

    // ---------------- haversine term: squares, clamps ----------------------
    logic signed [CW-1:0] s1, s2, ca, cb;
    always_comb begin
        s1 = c_fl[NS][0] ? -c_y[NS][0] : c_y[NS][0];
        s2 = c_fl[NS][1] ? -c_y[NS][1] : c_y[NS][1];
        ca = c_fl[NS][2] ? -c_x[NS][2] : c_x[NS][2];
        cb = c_fl[NS][3] ? -c_x[NS][3] : c_x[NS][3];
    end
    // magnitudes stay below 2^31 (|sin|,|cos| <= gain-scaled ~1.0 Q30)
    logic [30:0] h_m1, h_m2, h_ca, h_cb;
    logic        h_v, h_err;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            h_v <= 1'b0;
        end else if (i_adv) begin
            h_v <= c_v[NS];
        end
        if (i_adv) begin
            h_err <= c_err[NS];
            h_m1  <= 31'(s1[CW-1] ? -s1 : s1);
            h_m2  <= 31'(s2[CW-1] ? -s2 : s2);
            h_ca  <= ca[CW-1] ? '0 : ((ca > CW'(Q30_ONE)) ? Q30_ONE : 31'(ca));
            h_cb  <= cb[CW-1] ? '0 : ((cb > CW'(Q30_ONE)) ? Q30_ONE : 31'(cb));
        end
    end
    // products
    logic [61:0] p_sq1, p_sq2, p_cc;
    logic        p_v, p_err;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            p_v <= 1'b0;
        end else if (i_adv) begin
            p_v <= h_v;
        end
        if (i_adv) begin
            p_err <= h_err;
            p_sq1 <= 62'(h_m1) * 62'(h_m1);
            p_sq2 <= 62'(h_m2) * 62'(h_m2);
            p_cc  <= 62'(h_ca) * 62'(h_cb);
        end
    end
    logic [30:0] q_sq1, q_sq2, q_cc;
    logic        q_v, q_err;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            q_v <= 1'b0;
        end else if (i_adv) begin
            q_v <= p_v;
        end
        if (i_adv) begin
            q_err <= p_err;
            q_sq1 <= (p_sq1[61:30] > 32'(Q30_ONE)) ? Q30_ONE : p_sq1[60:30];
            q_sq2 <= (p_sq2[61:30] > 32'(Q30_ONE)) ? Q30_ONE : p_sq2[60:30];
            q_cc  <= p_cc[60:30];
        end
    end
    logic [61:0] m_prod;
    logic [30:0] m_sq1;
    logic        m_v, m_err;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_v <= 1'b0;
        end else if (i_adv) begin
            m_v <= q_v;
        end
        if (i_adv) begin
            m_err  <= q_err;
            m_sq1  <= q_sq1;
            m_prod <= 62'(q_sq2) * 62'(q_cc);
        end
    end
    logic [30:0] a_a;
    logic        a_v, a_err;
    logic [31:0] n_asum;
    assign n_asum = 32'(m_sq1) + 32'(m_prod[61:30]);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            a_v <= 1'b0;
        end else if (i_adv) begin
            a_v <= m_v;
        end
        if (i_adv) begin
            a_err <= m_err;
            a_a   <= (n_asum > 32'(Q30_ONE)) ? Q30_ONE : n_asum[30:0];
        end
    end

    // ---------------- two square roots, one result bit a stage -------------
    // radicands a<<30 and (1-a)<<30, up to 2^60; classic bit-pair method
    logic [61:0] t_n   [SQN+1][2];
    logic [31:0] t_res [SQN+1][2];
    logic        t_v   [SQN+1];
    logic        t_err [SQN+1];
    always_comb begin
        t_v[0]      = a_v;
        t_err[0]    = a_err;
        t_n[0][0]   = 62'(a_a) << 30;
        t_n[0][1]   = 62'(Q30_ONE - a_a) << 30;
        t_res[0][0] = '0;
        t_res[0][1] = '0;
    end
    for (genvar s = 0; s < SQN; s++) begin : g_sqrt
        localparam int SH = 2 * (SQN - 1 - s);
        logic [61:0] r_n [2];
        logic [31:0] r_res [2];
        logic        r_v, r_err;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_adv) begin
                r_v <= t_v[s];
            end
            if (i_adv) begin
                r_err <= t_err[s];
                for (int k = 0; k < 2; k++) begin
                    logic [63:0] trial;
                    // (2*root + 1) * 4^bit with the root bits found so far
                    trial = (64'(t_res[s][k]) << (SH + 2)) + (64'd1 << SH);
                    if (64'(t_n[s][k]) >= trial) begin
                        r_n[k]   <= t_n[s][k] - 62'(trial);
                        r_res[k] <= {t_res[s][k][30:0], 1'b1};
                    end else begin
                        r_n[k]   <= t_n[s][k];
                        r_res[k] <= {t_res[s][k][30:0], 1'b0};
                    end
                end
            end
        end
        assign t_n[s+1]   = r_n;
        assign t_res[s+1] = r_res;
        assign t_v[s+1]   = r_v;
        assign t_err[s+1] = r_err;
    end

    // ---------------- atan2 by vectoring CORDIC ----------------------------
    logic signed [CW-1:0] v_x [NS+1];
    logic signed [CW-1:0] v_y [NS+1];
    logic signed [33:0]   v_z [NS+1];
    logic                 v_v [NS+1];
    logic                 v_err [NS+1];
    always_comb begin
        v_x[0]   = CW'(t_res[SQN][1]);
        v_y[0]   = CW'(t_res[SQN][0]);
        v_z[0]   = '0;
        v_v[0]   = t_v[SQN];
        v_err[0] = t_err[SQN];
    end
    for (genvar s = 0; s < NS; s++) begin : g_vec
        logic signed [CW-1:0] r_x, r_y;
        logic signed [33:0]   r_z;
        logic                 r_v, r_err;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_adv) begin
                r_v <= v_v[s];
            end
            if (i_adv) begin
                r_err <= v_err[s];
                if (v_y[s] > 0) begin
                    r_x <= v_x[s] + (v_y[s] >>> s);
                    r_y <= v_y[s] - (v_x[s] >>> s);
                    r_z <= v_z[s] + 34'(atan_bam(6'(s)));
                end else begin
                    r_x <= v_x[s] - (v_y[s] >>> s);
                    r_y <= v_y[s] + (v_x[s] >>> s);
                    r_z <= v_z[s] - 34'(atan_bam(6'(s)));
                end
            end
        end
        assign v_x[s+1]   = r_x;
        assign v_y[s+1]   = r_y;
        assign v_z[s+1]   = r_z;
        assign v_v[s+1]   = r_v;
        assign v_err[s+1] = r_err;
    end

    // ---------------- scale: angle -> radians -> meters --------------------
    logic [31:0] k_c;
    logic        k_v, k_err;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            k_v <= 1'b0;
        end else if (i_adv) begin
            k_v <= v_v[NS];
        end
        if (i_adv) begin
            k_err <= v_err[NS];
            if (v_z[NS][33])
                k_c <= '0;
            else if (v_z[NS] > 34'sh4000_0000)
                k_c <= 32'h8000_0000;
            else
                k_c <= {v_z[NS][30:0], 1'b0};
        end
    end
    logic [63:0] k_rp;
    logic        kr_v, kr_err;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            kr_v <= 1'b0;
        end else if (i_adv) begin
            kr_v <= k_v;
        end
        if (i_adv) begin
            kr_err <= k_err;
            k_rp   <= 64'(k_c) * 64'(PI_Q30);
        end
    end
    logic [32:0] k_rad;
    logic        kd_v, kd_err;
    logic [64:0] n_radsum;
    assign n_radsum = 65'(k_rp) + 65'(64'd1 << 30);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            kd_v <= 1'b0;
        end else if (i_adv) begin
            kd_v <= kr_v;
        end
        if (i_adv) begin
            kd_err <= kr_err;
            k_rad  <= n_radsum[63:31];
        end
    end
    logic [55:0] k_dm;
    logic        km_v, km_err;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            km_v <= 1'b0;
        end else if (i_adv) begin
            km_v <= kd_v;
        end
        if (i_adv) begin
            km_err <= kd_err;
            k_dm   <= 56'(i_radius) * 56'(k_rad);
        end
    end
    logic [25:0] n_dist;
    assign n_dist = 26'((k_dm + (56'd1 << 29)) >> 30);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_adv) begin
            o_vld <= km_v;
        end
        if (i_adv) begin
            o_range_error <= km_err;
            if (km_err)
                o_distance_m <= '0;
            else if (n_dist > 26'(DIST_MAX))
                o_distance_m <= DIST_MAX;
            else
                o_distance_m <= n_dist[24:0];
        end
    end

endmodule

// ===== rtl/haversine_distance.sv =====
// ----------------------------------------------------------------------------
// haversine_distance
// Great-circle distance between two lat/lon points by the haversine formula,
// fully pipelined CORDIC sin/cos, digit square roots and atan2 CORDIC.
// ----------------------------------------------------------------------------
// channel | valid    | stall    | payload
// in      | i_valid  | o_stall  | i_lat_a i_lon_a i_lat_b i_lon_b
// out     | o_valid  | i_stall  | o_distance_m o_range_error
// cfg     | i_cfg_we |  -       | i_cfg_wdata (earth radius, meters)
//
// One request enters per cycle while o_stall is low. Its path runs through range
// check, angle scaling, a two-stage reciprocal divide and quadrant fold (5),
// 2*CORDIC_STAGES CORDIC steps, 5 haversine registers, 31 root steps and
// 5 scaling registers. The whole pipe freezes while the output holds and
// i_stall is high; o_stall is then high only when the output register is full.
// Reset is synchronous active low; it clears valid bits and loads the radius
// 6371000.
// ----------------------------------------------------------------------------
module haversine_distance
    import hvd_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [23:0] i_lat_a,
    input  logic [24:0] i_lon_a,
    input  logic [23:0] i_lat_b,
    input  logic [24:0] i_lon_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [24:0] o_distance_m,
    output logic        o_range_error,
    input  logic        i_cfg_we,
    input  logic [22:0] i_cfg_wdata
);

    logic [22:0] r_radius;
    logic        w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    // advance whenever the output slot is empty or being taken
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    hvd_pipe #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
        .CORDIC_STAGES  (CORDIC_STAGES)
    ) u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_vld         (i_valid),
        .i_lat_a       (i_lat_a),
        .i_lon_a       (i_lon_a),
        .i_lat_b       (i_lat_b),
        .i_lon_b       (i_lon_b),
        .i_radius      (r_radius),
        .o_vld         (o_valid),
        .o_distance_m  (o_distance_m),
        .o_range_error (o_range_error)
    );

endmodule
